@@ design/bba_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, command and status types for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int TOP_BLOCKS_DEF      = 32;
  localparam int TOP_ORDER_DEF       = 10;
  localparam int MIN_BLOCK_BYTES_DEF = 128;
  localparam int HEADER_RESET        = 32;

  localparam int CMD_W  = 1;
  localparam int REQ_W  = 27;
  localparam int OFF_W  = 22;
  localparam int ORD_W  = 4;
  localparam int CNT_W  = 16;
  localparam int BYTE_W = 23;
  localparam int HDR_W  = 7;
  localparam int ST_W   = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [ST_W-1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [ST_W-1:0] ST_INVALID   = 2'd3;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NOP       = 5'd0;
  localparam logic [OP_W-1:0] OP_CLEAR     = 5'd1;
  localparam logic [OP_W-1:0] OP_LATCH     = 5'd2;
  localparam logic [OP_W-1:0] OP_AL_INIT   = 5'd3;
  localparam logic [OP_W-1:0] OP_SCAN_RD   = 5'd4;
  localparam logic [OP_W-1:0] OP_SCAN_NEXT = 5'd5;
  localparam logic [OP_W-1:0] OP_TAKE      = 5'd6;
  localparam logic [OP_W-1:0] OP_SP_STEP   = 5'd7;
  localparam logic [OP_W-1:0] OP_SP_RD     = 5'd8;
  localparam logic [OP_W-1:0] OP_SP_WR     = 5'd9;
  localparam logic [OP_W-1:0] OP_AL_UNIT   = 5'd10;
  localparam logic [OP_W-1:0] OP_USE_RD_A  = 5'd11;
  localparam logic [OP_W-1:0] OP_USE_RD_F  = 5'd12;
  localparam logic [OP_W-1:0] OP_GRANT     = 5'd13;
  localparam logic [OP_W-1:0] OP_FREE_PRE  = 5'd14;
  localparam logic [OP_W-1:0] OP_RELEASE   = 5'd15;
  localparam logic [OP_W-1:0] OP_MG_RD     = 5'd16;
  localparam logic [OP_W-1:0] OP_MG_TAKE   = 5'd17;
  localparam logic [OP_W-1:0] OP_MG_SET    = 5'd18;
  localparam logic [OP_W-1:0] OP_RESULT    = 5'd19;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ST_W-1:0] res_status;
  } bba_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic too_large;
    logic word_nz;
    logic scan_exhaust;
    logic at_k;
    logic pre_bad;
    logic use_bad;
    logic buddy_free;
    logic k_top;
  } bba_stat_t;

  function automatic int clog1(input int v);
    return (v > 1) ? $clog2(v) : 1;
  endfunction

  function automatic int words_of(input int bits);
    return (bits + 31) / 32;
  endfunction

  function automatic int map_word_base(input int units, input int k);
    int b;
    b = 0;
    for (int j = 0; j < k; j++) begin
      b = b + words_of(units >> j);
    end
    return b;
  endfunction

endpackage
`default_nettype wire

@@ design/bba_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for the allocator: clearing pass, search, split, free and merge.
// ----------------------------------------------------------------------------
module bba_ctrl (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [bba_pkg::CMD_W-1:0]   in_command,
  output logic                        out_valid,
  input  wire                         out_ready,
  output bba_pkg::bba_cmd_t           cmd,
  input  bba_pkg::bba_stat_t          stat
);
  import bba_pkg::*;

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_AL_INIT = 5'd2;
  localparam logic [4:0] S_SC_RD   = 5'd3;
  localparam logic [4:0] S_SC_CHK  = 5'd4;
  localparam logic [4:0] S_TAKE    = 5'd5;
  localparam logic [4:0] S_SP_STEP = 5'd6;
  localparam logic [4:0] S_SP_RD   = 5'd7;
  localparam logic [4:0] S_SP_WR   = 5'd8;
  localparam logic [4:0] S_UNIT    = 5'd9;
  localparam logic [4:0] S_USE_A   = 5'd10;
  localparam logic [4:0] S_GRANT   = 5'd11;
  localparam logic [4:0] S_FR_CHK  = 5'd12;
  localparam logic [4:0] S_USE_F   = 5'd13;
  localparam logic [4:0] S_REL     = 5'd14;
  localparam logic [4:0] S_MG_RD   = 5'd15;
  localparam logic [4:0] S_MG_CHK  = 5'd16;
  localparam logic [4:0] S_MG_TAKE = 5'd17;
  localparam logic [4:0] S_MG_SET  = 5'd18;
  localparam logic [4:0] S_RESULT  = 5'd19;

  logic [4:0]      state_r, state_nxt;
  logic [ST_W-1:0] code_r, code_nxt;
  logic            out_valid_r;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    code_nxt       = code_r;
    cmd.op         = OP_NOP;
    cmd.res_status = code_r;
    case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = (in_command == CMD_ALLOC) ? S_AL_INIT : S_FR_CHK;
        end
      end
      S_AL_INIT: begin
        if (stat.too_large) begin
          code_nxt  = ST_TOO_LARGE;
          state_nxt = S_RESULT;
        end else begin
          cmd.op    = OP_AL_INIT;
          state_nxt = S_SC_RD;
        end
      end
      S_SC_RD: begin
        cmd.op    = OP_SCAN_RD;
        state_nxt = S_SC_CHK;
      end
      S_SC_CHK: begin
        if (stat.word_nz) begin
          state_nxt = S_TAKE;
        end else if (stat.scan_exhaust) begin
          code_nxt  = ST_NO_SPACE;
          state_nxt = S_RESULT;
        end else begin
          cmd.op    = OP_SCAN_NEXT;
          state_nxt = S_SC_RD;
        end
      end
      S_TAKE: begin
        cmd.op    = OP_TAKE;
        state_nxt = stat.at_k ? S_UNIT : S_SP_STEP;
      end
      S_SP_STEP: begin
        cmd.op    = OP_SP_STEP;
        state_nxt = S_SP_RD;
      end
      S_SP_RD: begin
        cmd.op    = OP_SP_RD;
        state_nxt = S_SP_WR;
      end
      S_SP_WR: begin
        cmd.op    = OP_SP_WR;
        state_nxt = stat.at_k ? S_UNIT : S_SP_STEP;
      end
      S_UNIT: begin
        cmd.op    = OP_AL_UNIT;
        state_nxt = S_USE_A;
      end
      S_USE_A: begin
        cmd.op    = OP_USE_RD_A;
        state_nxt = S_GRANT;
      end
      S_GRANT: begin
        cmd.op    = OP_GRANT;
        code_nxt  = ST_OK;
        state_nxt = S_RESULT;
      end
      S_FR_CHK: begin
        if (stat.pre_bad) begin
          code_nxt  = ST_INVALID;
          state_nxt = S_RESULT;
        end else begin
          cmd.op    = OP_FREE_PRE;
          state_nxt = S_USE_F;
        end
      end
      S_USE_F: begin
        cmd.op    = OP_USE_RD_F;
        state_nxt = S_REL;
      end
      S_REL: begin
        if (stat.use_bad) begin
          code_nxt  = ST_INVALID;
          state_nxt = S_RESULT;
        end else begin
          cmd.op    = OP_RELEASE;
          state_nxt = S_MG_RD;
        end
      end
      S_MG_RD: begin
        cmd.op    = OP_MG_RD;
        state_nxt = S_MG_CHK;
      end
      S_MG_CHK: begin
        state_nxt = (!stat.k_top && stat.buddy_free) ? S_MG_TAKE : S_MG_SET;
      end
      S_MG_TAKE: begin
        cmd.op    = OP_MG_TAKE;
        state_nxt = S_MG_RD;
      end
      S_MG_SET: begin
        cmd.op    = OP_MG_SET;
        code_nxt  = ST_OK;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (slot_free) begin
          cmd.op    = OP_RESULT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      code_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      if (cmd.op == OP_RESULT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> state_r == S_CLEAR)
    else $error("state after reset is not the clearing pass");

  a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && slot_free) |=> out_valid_r)
    else $error("result state did not present a transaction");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RESULT)
    else $error("output valid rose outside the result state");

endmodule
`default_nettype wire

@@ design/bba_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bba_dp
// Allocator datapath: free map, in-use and order memories, counters, results.
// ----------------------------------------------------------------------------
module bba_dp #(
  parameter int TOP_BLOCKS      = bba_pkg::TOP_BLOCKS_DEF,
  parameter int TOP_ORDER       = bba_pkg::TOP_ORDER_DEF,
  parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_wr_en,
  input  wire  [bba_pkg::HDR_W-1:0]    cfg_wr_data,
  input  wire  [bba_pkg::REQ_W-1:0]    in_request_bytes,
  input  wire  [bba_pkg::OFF_W-1:0]    in_payload_offset_in,
  input  bba_pkg::bba_cmd_t            cmd,
  output bba_pkg::bba_stat_t           stat,
  output logic [bba_pkg::ST_W-1:0]     out_status,
  output logic [bba_pkg::OFF_W-1:0]    out_payload_offset,
  output logic [bba_pkg::ORD_W-1:0]    out_block_order,
  output logic [bba_pkg::CNT_W-1:0]    out_free_blocks,
  output logic [bba_pkg::CNT_W-1:0]    out_allocated_blocks,
  output logic [bba_pkg::BYTE_W-1:0]   out_free_payload,
  output logic [bba_pkg::BYTE_W-1:0]   out_block_payload
);
  import bba_pkg::*;

  localparam int     UNITS     = TOP_BLOCKS << TOP_ORDER;
  localparam int     UNIT_W    = clog1(UNITS);
  localparam int     KW        = clog1(TOP_ORDER + 2);
  localparam int     MAP_WORDS = map_word_base(UNITS, TOP_ORDER + 1);
  localparam int     MW_W      = clog1(MAP_WORDS + 1);
  localparam int     MA_W      = clog1(MAP_WORDS);
  localparam int     USE_WORDS = words_of(UNITS);
  localparam int     UA_W      = clog1(USE_WORDS);
  localparam int     LOG       = $clog2(MIN_BLOCK_BYTES);
  localparam int     CLR_N     = (MAP_WORDS > USE_WORDS) ? MAP_WORDS : USE_WORDS;
  localparam int     CLR_W     = clog1(CLR_N);
  localparam longint TOP_BYTES = longint'(MIN_BLOCK_BYTES) << TOP_ORDER;
  localparam longint REGION    = longint'(UNITS) * longint'(MIN_BLOCK_BYTES);
  localparam logic [BYTE_W-1:0] BYTES_RESET =
    BYTE_W'(REGION - longint'(TOP_BLOCKS) * longint'(HEADER_RESET));
  localparam logic [OFF_W-1:0] LOW_MASK = OFF_W'((longint'(1) << LOG) - 1);

  logic [31:0]       map_mem [MAP_WORDS];
  logic [31:0]       use_mem [USE_WORDS];
  logic [KW-1:0]     ord_mem [UNITS];

  logic [MW_W-1:0]   wbase_tab [TOP_ORDER+2];

  logic [HDR_W-1:0]  hdr_r;
  logic [REQ_W-1:0]  req_r;
  logic [OFF_W-1:0]  poff_r;
  logic [KW-1:0]     k_r, m_r, res_ord_r;
  logic [UNIT_W-1:0] j_r, unit_r;
  logic [MW_W-1:0]   w_r;
  logic [OFF_W-1:0]  res_off_r;
  logic [CNT_W-1:0]  free_cnt_r, blk_cnt_r;
  logic [BYTE_W-1:0] free_byte_r, blk_byte_r;
  logic [CLR_W-1:0]  clr_r;
  logic [31:0]       map_rd_r, use_rd_r;
  logic [KW-1:0]     ord_rd_r;

  logic              map_we, map_re, use_we, use_re;
  logic [MA_W-1:0]   map_addr;
  logic [31:0]       map_wdata, use_wdata, init_word;
  logic [UA_W-1:0]   use_addr;

  logic [REQ_W:0]    tot;
  logic [KW-1:0]     k_calc;
  logic [4:0]        lo;
  logic [MW_W-1:0]   scan_rel;
  logic [UNIT_W-1:0] scan_j, sp_idx;
  logic [MA_W-1:0]   sp_addr, mg_addr;
  logic [4:0]        sp_pos, buddy_pos, own_pos, unit_pos;
  logic [OFF_W-1:0]  head;
  logic [MW_W-1:0]   wbase_top;

  genvar gi;
  generate
    for (gi = 0; gi < TOP_ORDER + 2; gi++) begin : g_wbase
      assign wbase_tab[gi] = MW_W'(map_word_base(UNITS, gi));
    end
  endgenerate

  function automatic logic [BYTE_W-1:0] size_of(input logic [KW-1:0] ord);
    return BYTE_W'(longint'(MIN_BLOCK_BYTES) << ord);
  endfunction

  always_comb begin
    tot    = {1'b0, req_r} + (REQ_W + 1)'(hdr_r);
    k_calc = KW'(TOP_ORDER);
    for (int g = TOP_ORDER; g >= 0; g--) begin
      if ((longint'(MIN_BLOCK_BYTES) << g) >= longint'(tot)) begin
        k_calc = KW'(g);
      end
    end
    lo = 5'd0;
    for (int b = 31; b >= 0; b--) begin
      if (map_rd_r[b]) begin
        lo = 5'(b);
      end
    end
    wbase_top = wbase_tab[TOP_ORDER];
    init_word = '0;
    for (int b = 0; b < 32; b++) begin
      if ((MW_W'(clr_r) >= wbase_top) &&
          ((int'(MW_W'(clr_r) - wbase_top) * 32 + b) < TOP_BLOCKS)) begin
        init_word[b] = 1'b1;
      end
    end
  end

  assign scan_rel  = w_r - wbase_tab[m_r];
  assign scan_j    = (UNIT_W'(scan_rel) << 5) | UNIT_W'(lo);
  assign sp_idx    = j_r + UNIT_W'(1);
  assign sp_addr   = MA_W'(wbase_tab[m_r] + MW_W'(sp_idx >> 5));
  assign mg_addr   = MA_W'(wbase_tab[k_r] + MW_W'(j_r >> 5));
  assign sp_pos    = 5'(sp_idx);
  assign buddy_pos = 5'(j_r ^ UNIT_W'(1));
  assign own_pos   = 5'(j_r);
  assign unit_pos  = 5'(unit_r);
  assign head      = poff_r - OFF_W'(hdr_r);

  always_comb begin
    stat.clear_done   = (clr_r == CLR_W'(CLR_N - 1));
    stat.too_large    = longint'(tot) > TOP_BYTES;
    stat.word_nz      = (map_rd_r != 32'd0);
    stat.scan_exhaust = (w_r == wbase_tab[KW'(m_r + KW'(1))] - MW_W'(1)) &&
                        (m_r == KW'(TOP_ORDER));
    stat.at_k         = (m_r == k_r);
    stat.pre_bad      = (poff_r < OFF_W'(hdr_r)) || ((head & LOW_MASK) != '0) ||
                        (longint'(head >> LOG) >= longint'(UNITS));
    stat.use_bad      = !use_rd_r[unit_pos] || (ord_rd_r > KW'(TOP_ORDER)) ||
                        (((unit_r >> ord_rd_r) << ord_rd_r) != unit_r);
    stat.buddy_free   = map_rd_r[buddy_pos];
    stat.k_top        = (k_r == KW'(TOP_ORDER));
  end

  always_comb begin
    map_we    = 1'b0;
    map_re    = 1'b0;
    map_addr  = mg_addr;
    map_wdata = map_rd_r;
    use_we    = 1'b0;
    use_re    = 1'b0;
    use_addr  = UA_W'(unit_r >> 5);
    use_wdata = use_rd_r;
    case (cmd.op)
      OP_CLEAR: begin
        map_addr  = MA_W'(clr_r);
        map_we    = (int'(clr_r) < MAP_WORDS);
        map_wdata = init_word;
        use_addr  = UA_W'(clr_r);
        use_we    = (int'(clr_r) < USE_WORDS);
        use_wdata = '0;
      end
      OP_SCAN_RD: begin
        map_addr = MA_W'(w_r);
        map_re   = 1'b1;
      end
      OP_TAKE: begin
        map_addr  = MA_W'(w_r);
        map_we    = 1'b1;
        map_wdata = map_rd_r & ~(32'd1 << lo);
      end
      OP_SP_RD: begin
        map_addr = sp_addr;
        map_re   = 1'b1;
      end
      OP_SP_WR: begin
        map_addr  = sp_addr;
        map_we    = 1'b1;
        map_wdata = map_rd_r | (32'd1 << sp_pos);
      end
      OP_USE_RD_A, OP_USE_RD_F: begin
        use_re = 1'b1;
      end
      OP_GRANT: begin
        use_we    = 1'b1;
        use_wdata = use_rd_r | (32'd1 << unit_pos);
      end
      OP_RELEASE: begin
        use_we    = 1'b1;
        use_wdata = use_rd_r & ~(32'd1 << unit_pos);
      end
      OP_MG_RD: begin
        map_re = 1'b1;
      end
      OP_MG_TAKE: begin
        map_we    = 1'b1;
        map_wdata = map_rd_r & ~(32'd1 << buddy_pos);
      end
      OP_MG_SET: begin
        map_we    = 1'b1;
        map_wdata = map_rd_r | (32'd1 << own_pos);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_addr] <= map_wdata;
    end
    if (map_re) begin
      map_rd_r <= map_mem[map_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (use_we) begin
      use_mem[use_addr] <= use_wdata;
    end
    if (use_re) begin
      use_rd_r <= use_mem[use_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_USE_RD_A) begin
      ord_mem[unit_r] <= k_r;
    end
    if (cmd.op == OP_USE_RD_F) begin
      ord_rd_r <= ord_mem[unit_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r       <= HDR_W'(HEADER_RESET);
      clr_r       <= '0;
      free_cnt_r  <= CNT_W'(TOP_BLOCKS);
      blk_cnt_r   <= CNT_W'(TOP_BLOCKS);
      free_byte_r <= BYTES_RESET;
      blk_byte_r  <= BYTES_RESET;
    end else begin
      if (cfg_wr_en) begin
        hdr_r <= cfg_wr_data;
      end
      case (cmd.op)
        OP_CLEAR: begin
          clr_r <= clr_r + CLR_W'(1);
        end
        OP_SP_WR: begin
          free_cnt_r  <= free_cnt_r + CNT_W'(1);
          blk_cnt_r   <= blk_cnt_r + CNT_W'(1);
          free_byte_r <= free_byte_r - BYTE_W'(hdr_r);
          blk_byte_r  <= blk_byte_r - BYTE_W'(hdr_r);
        end
        OP_GRANT: begin
          free_cnt_r  <= free_cnt_r - CNT_W'(1);
          free_byte_r <= free_byte_r - (size_of(k_r) - BYTE_W'(hdr_r));
        end
        OP_RELEASE: begin
          free_cnt_r  <= free_cnt_r + CNT_W'(1);
          free_byte_r <= free_byte_r + (size_of(ord_rd_r) - BYTE_W'(hdr_r));
        end
        OP_MG_TAKE: begin
          free_cnt_r  <= free_cnt_r - CNT_W'(1);
          blk_cnt_r   <= blk_cnt_r - CNT_W'(1);
          free_byte_r <= free_byte_r + BYTE_W'(hdr_r);
          blk_byte_r  <= blk_byte_r + BYTE_W'(hdr_r);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        req_r  <= in_request_bytes;
        poff_r <= in_payload_offset_in;
      end
      OP_AL_INIT: begin
        k_r <= k_calc;
        m_r <= k_calc;
        w_r <= wbase_tab[k_calc];
      end
      OP_SCAN_NEXT: begin
        w_r <= w_r + MW_W'(1);
        if (w_r == wbase_tab[KW'(m_r + KW'(1))] - MW_W'(1)) begin
          m_r <= m_r + KW'(1);
        end
      end
      OP_TAKE: begin
        j_r <= scan_j;
      end
      OP_SP_STEP: begin
        m_r <= m_r - KW'(1);
        j_r <= j_r << 1;
      end
      OP_AL_UNIT: begin
        unit_r <= j_r << k_r;
      end
      OP_GRANT: begin
        res_off_r <= OFF_W'((longint'(unit_r) << LOG) + longint'(hdr_r));
        res_ord_r <= k_r;
      end
      OP_FREE_PRE: begin
        unit_r <= UNIT_W'(head >> LOG);
      end
      OP_RELEASE: begin
        k_r <= ord_rd_r;
        j_r <= unit_r >> ord_rd_r;
      end
      OP_MG_TAKE: begin
        j_r <= j_r >> 1;
        k_r <= k_r + KW'(1);
      end
      OP_MG_SET: begin
        res_off_r <= OFF_W'((longint'(j_r << k_r) << LOG) + longint'(hdr_r));
        res_ord_r <= k_r;
      end
      OP_RESULT: begin
        out_status           <= cmd.res_status;
        out_payload_offset   <= (cmd.res_status == ST_OK) ? res_off_r : '0;
        out_block_order      <= (cmd.res_status == ST_OK) ? ORD_W'(res_ord_r) : '0;
        out_free_blocks      <= free_cnt_r;
        out_allocated_blocks <= blk_cnt_r;
        out_free_payload     <= free_byte_r;
        out_block_payload    <= blk_byte_r;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

@@ design/buddy_block_allocator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_block_allocator_top
// Binary buddy allocator with a free bit map per order and usage counters.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    command, request, payload offset
//   out_     output     out_valid / out_ready  status, offset, order, counters
//   cfg_     input      cfg_wr_en              header_bytes
//
// From acceptance to a valid result, allocate reads and checks each free-map
// word scanned (up to the whole map, 2047 words by default), then reads and
// writes the map for each split step; free checks the offset and in-use
// mark, then reads the map for each merge step; a failed check ends sooner.
// The free-map memory is single-port. After reset a clearing pass over
// max(map words, in-use words) words (2047 by default) runs before the
// first transaction is accepted. A stalled output holds the finished result
// while the next transaction is worked on.
// ----------------------------------------------------------------------------
module buddy_block_allocator_top #(
  parameter int TOP_BLOCKS      = bba_pkg::TOP_BLOCKS_DEF,
  parameter int TOP_ORDER       = bba_pkg::TOP_ORDER_DEF,
  parameter int MIN_BLOCK_BYTES = bba_pkg::MIN_BLOCK_BYTES_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_wr_en,
  input  wire  [bba_pkg::HDR_W-1:0]    cfg_wr_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [bba_pkg::CMD_W-1:0]    in_command,
  input  wire  [bba_pkg::REQ_W-1:0]    in_request_bytes,
  input  wire  [bba_pkg::OFF_W-1:0]    in_payload_offset_in,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [bba_pkg::ST_W-1:0]     out_status,
  output logic [bba_pkg::OFF_W-1:0]    out_payload_offset,
  output logic [bba_pkg::ORD_W-1:0]    out_block_order,
  output logic [bba_pkg::CNT_W-1:0]    out_free_blocks,
  output logic [bba_pkg::CNT_W-1:0]    out_allocated_blocks,
  output logic [bba_pkg::BYTE_W-1:0]   out_free_payload,
  output logic [bba_pkg::BYTE_W-1:0]   out_block_payload
);
  import bba_pkg::*;

  bba_cmd_t  cmd;
  bba_stat_t stat;

  bba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  bba_dp #(
    .TOP_BLOCKS      (TOP_BLOCKS),
    .TOP_ORDER       (TOP_ORDER),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_request_bytes     (in_request_bytes),
    .in_payload_offset_in (in_payload_offset_in),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_status           (out_status),
    .out_payload_offset   (out_payload_offset),
    .out_block_order      (out_block_order),
    .out_free_blocks      (out_free_blocks),
    .out_allocated_blocks (out_allocated_blocks),
    .out_free_payload     (out_free_payload),
    .out_block_payload    (out_block_payload)
  );

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Drives allocate and free transactions into the allocator under random
// bursts and output stalls. A predictor class tracks the free map, the in-use
// marks and the usage counters, and checks each result in order.
// ----------------------------------------------------------------------------
module testbench;
  import bba_pkg::*;

  localparam int UNITS     = 32768;
  localparam int TOP_ORD   = 10;
  localparam int TOP_BYTES = 131072;
  localparam int WD_LIMIT  = 30000;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [OFF_W-1:0]  offset;
    logic [ORD_W-1:0]  order;
    logic [CNT_W-1:0]  free_blks;
    logic [CNT_W-1:0]  all_blks;
    logic [BYTE_W-1:0] free_byt;
    logic [BYTE_W-1:0] all_byt;
  } alloc_result_t;

  class buddy_predictor;
    bit free_bit [0:TOP_ORD][0:UNITS-1];
    bit in_use [0:UNITS-1];
    logic [3:0] blk_order [0:UNITS-1];
    logic [CNT_W-1:0] free_blks, all_blks;
    logic [BYTE_W-1:0] free_byt, all_byt;
    logic [HDR_W-1:0] hdr;
    alloc_result_t expected_q[$];
    int errors;

    function new();
      for (int i = 0; i < TOP_BLOCKS_DEF; i++) free_bit[TOP_ORD][i] = 1'b1;
      hdr = HDR_W'(HEADER_RESET);
      free_blks = CNT_W'(TOP_BLOCKS_DEF);
      all_blks = CNT_W'(TOP_BLOCKS_DEF);
      free_byt = 23'd4193280;
      all_byt = 23'd4193280;
      errors = 0;
    endfunction

    function alloc_result_t report(logic [ST_W-1:0] st, longint off, int ord);
      alloc_result_t r;
      r.status = st;
      r.offset = off[OFF_W-1:0];
      r.order = ord[ORD_W-1:0];
      r.free_blks = free_blks;
      r.all_blks = all_blks;
      r.free_byt = free_byt;
      r.all_byt = all_byt;
      return r;
    endfunction

    function alloc_result_t grant(logic [REQ_W-1:0] req);
      longint tot;
      int k, m, j;
      bit found;
      tot = longint'(req) + hdr;
      k = 0;
      found = 0;
      j = 0;
      if (tot > TOP_BYTES) return report(ST_TOO_LARGE, 0, 0);
      while (k < TOP_ORD && (longint'(128) << k) < tot) k++;
      for (m = k; m <= TOP_ORD && !found; m++) begin
        for (int i = 0; i < (UNITS >> m) && !found; i++) begin
          if (free_bit[m][i]) begin
            found = 1;
            j = i;
          end
        end
      end
      if (!found) return report(ST_NO_SPACE, 0, 0);
      m--;
      free_bit[m][j] = 1'b0;
      while (m > k) begin
        m--;
        j = j << 1;
        free_bit[m][j + 1] = 1'b1;
        free_blks++;
        all_blks++;
        free_byt -= hdr;
        all_byt -= hdr;
      end
      in_use[j << k] = 1'b1;
      blk_order[j << k] = 4'(k);
      free_blks--;
      free_byt -= (BYTE_W'(128 << k) - hdr);
      return report(ST_OK, longint'(j << k) * 128 + hdr, k);
    endfunction

    function alloc_result_t reclaim(logic [OFF_W-1:0] poff);
      int head, unit, k, j;
      if (poff < hdr) return report(ST_INVALID, 0, 0);
      head = poff - hdr;
      unit = head / 128;
      if (head % 128 != 0 || !in_use[unit] || blk_order[unit] > TOP_ORD)
        return report(ST_INVALID, 0, 0);
      k = blk_order[unit];
      if ((unit & ((1 << k) - 1)) != 0) return report(ST_INVALID, 0, 0);
      in_use[unit] = 1'b0;
      free_blks++;
      free_byt += (BYTE_W'(128 << k) - hdr);
      j = unit >> k;
      while (k < TOP_ORD && free_bit[k][j ^ 1]) begin
        free_bit[k][j ^ 1] = 1'b0;
        free_blks--;
        all_blks--;
        free_byt += hdr;
        all_byt += hdr;
        j = j >> 1;
        k++;
      end
      free_bit[k][j] = 1'b1;
      return report(ST_OK, longint'(j << k) * 128 + hdr, k);
    endfunction

    function alloc_result_t note_input(logic [CMD_W-1:0] cmd, logic [REQ_W-1:0] req,
                                       logic [OFF_W-1:0] poff);
      alloc_result_t r;
      r = (cmd == CMD_ALLOC) ? grant(req) : reclaim(poff);
      expected_q.push_back(r);
      return r;
    endfunction

    function void field_cmp(string name, longint e, longint a);
      if (e != a) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(alloc_result_t a);
      alloc_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual status %0d", $time,
                 a.status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      field_cmp("status", e.status, a.status);
      field_cmp("payload_offset", e.offset, a.offset);
      field_cmp("block_order", e.order, a.order);
      field_cmp("free_blocks", e.free_blks, a.free_blks);
      field_cmp("allocated_blocks", e.all_blks, a.all_blks);
      field_cmp("free_payload", e.free_byt, a.free_byt);
      field_cmp("block_payload", e.all_byt, a.all_byt);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [HDR_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_command = CMD_ALLOC;
  logic [REQ_W-1:0] in_request_bytes = '0;
  logic [OFF_W-1:0] in_payload_offset_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ST_W-1:0] out_status;
  logic [OFF_W-1:0] out_payload_offset;
  logic [ORD_W-1:0] out_block_order;
  logic [CNT_W-1:0] out_free_blocks, out_allocated_blocks;
  logic [BYTE_W-1:0] out_free_payload, out_block_payload;

  buddy_predictor sb = new();
  int live_units[$];
  int burst_left = 4;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_cycle = 0;
  int idle_cycles = 0;

  buddy_block_allocator_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_request_bytes(in_request_bytes), .in_payload_offset_in(in_payload_offset_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_payload_offset(out_payload_offset), .out_block_order(out_block_order),
    .out_free_blocks(out_free_blocks), .out_allocated_blocks(out_allocated_blocks),
    .out_free_payload(out_free_payload), .out_block_payload(out_block_payload)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = 400;
      out_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 250) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (rx_cycle % 7) < 2;
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{out_status, out_payload_offset, out_block_order,
                        out_free_blocks, out_allocated_blocks, out_free_payload,
                        out_block_payload});
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic drive(logic [CMD_W-1:0] cmd, logic [REQ_W-1:0] req,
                       logic [OFF_W-1:0] poff);
    alloc_result_t r;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_request_bytes <= req;
    in_payload_offset_in <= poff;
    do @(posedge clk); while (!in_ready);
    r = sb.note_input(cmd, req, poff);
    if (r.status == ST_OK && cmd == CMD_ALLOC) begin
      live_units.push_back((int'(r.offset) - sb.hdr) / 128);
    end else if (r.status == ST_OK) begin
      foreach (live_units[i]) begin
        if (live_units[i] * 128 + sb.hdr == poff) begin
          live_units.delete(i);
          break;
        end
      end
    end
  endtask

  task automatic send(logic [CMD_W-1:0] cmd, logic [REQ_W-1:0] req,
                      logic [OFF_W-1:0] poff, bit no_gap = 0);
    drive(cmd, req, poff);
    burst_left--;
    if (burst_left <= 0 && !no_gap) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_header(logic [HDR_W-1:0] h);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.hdr = h;
  endtask

  task automatic free_unit(int unit, bit no_gap = 0);
    send(CMD_FREE, REQ_W'($urandom), OFF_W'(unit * 128 + sb.hdr), no_gap);
  endtask

  task automatic random_item();
    int sel, ord, lim;
    sel = $urandom_range(0, 99);
    if (live_units.size() > 80 && sel < 55) sel = 60;
    if (sel < 55) begin
      ord = ($urandom_range(0, 9) == 0) ? $urandom_range(4, TOP_ORD) : $urandom_range(0, 3);
      lim = (128 << ord) - sb.hdr;
      send(CMD_ALLOC, REQ_W'($urandom_range(0, lim)), OFF_W'($urandom));
    end else if (sel < 88 && live_units.size() > 0) begin
      free_unit(live_units[$urandom_range(0, live_units.size() - 1)]);
    end else if (sel < 92) begin
      send(CMD_ALLOC, REQ_W'($urandom), OFF_W'($urandom));
    end else if (sel < 96) begin
      send(CMD_FREE, REQ_W'($urandom), OFF_W'($urandom));
    end else begin
      send(CMD_FREE, REQ_W'($urandom), OFF_W'($urandom_range(0, 255) * 128 + sb.hdr +
                                               $urandom_range(0, 1)));
    end
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && n >= 80) hold_reqs++;
      random_item();
    end
  endtask

  task automatic fill_and_empty();
    alloc_result_t last;
    do begin
      send(CMD_ALLOC, REQ_W'(TOP_BYTES - sb.hdr), OFF_W'($urandom), 1);
      last = sb.expected_q[$];
    end while (last.status == ST_OK);
    send(CMD_ALLOC, REQ_W'(0), OFF_W'($urandom), 1);
    while (live_units.size() > 0) free_unit(live_units[0], 1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send(CMD_ALLOC, REQ_W'(0), '0);
    send(CMD_ALLOC, REQ_W'(96), '1);
    send(CMD_ALLOC, REQ_W'(97), '0);
    send(CMD_ALLOC, REQ_W'(TOP_BYTES - 32), '0);
    send(CMD_ALLOC, REQ_W'(TOP_BYTES - 31), '0);
    send(CMD_ALLOC, '1, '0);
    send(CMD_FREE, '0, OFF_W'(0));
    send(CMD_FREE, '1, OFF_W'(33));
    send(CMD_FREE, '0, '1);
    send(CMD_FREE, '0, OFF_W'(32 + 128 * 5));
    send(CMD_FREE, '0, OFF_W'(32));
    send(CMD_FREE, '0, OFF_W'(32));
    while (live_units.size() > 0) free_unit(live_units[0]);
    drain();
    set_header(7'd0);
    fill_and_empty();
    random_phase(90);
    drain();
    set_header(7'd127);
    random_phase(80);
    fill_and_empty();
    drain();
    set_header(HDR_W'($urandom_range(1, 126)));
    random_phase(60);
    while (live_units.size() > 0) free_unit(live_units[0]);
    drain();
    set_header(7'd32);
    random_phase(40);
    in_valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
